### rtl/fla_pkg.sv
`default_nettype none

package fla_pkg;

    // Sizing of the page store.
    localparam int MAX_PAGES   = 1024;
    localparam int GROWTH_STEP = 16;
    localparam int PAGE_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int RAM_DEPTH   = 1 << PAGE_W;
    localparam int GROW_IDX_W  = (GROWTH_STEP > 1) ? $clog2(GROWTH_STEP) : 1;

    // Request codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;       // capture the request beat
        logic       grow_write;   // write one link of the fresh run
        logic       grow_finish;  // make the run the list, raise the count
        logic       pop;          // head takes the link just read
        logic       push;         // link the freed page in front of the head
        logic       load_result;  // register a result beat
        logic       result_page;  // result carries the old head page
        logic [1:0] result_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd;
        logic head_zero;
        logic growth_full;
        logic free_invalid;
        logic grow_last;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/fla_ram.sv
`default_nettype none

module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/fla_datapath.sv
`default_nettype none

module fla_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fla_pkg::t_dp_cmd             i_dp_cmd,
    input  wire logic                         i_cmd,
    input  wire logic [fla_pkg::PAGE_W-1:0]   i_page_number,
    output      fla_pkg::t_dp_status          o_dp_status,
    output      logic [fla_pkg::PAGE_W-1:0]   o_allocated_page,
    output      logic [1:0]                   o_status
);

    logic                            r_cmd;
    logic [fla_pkg::PAGE_W-1:0]      r_page;
    logic [fla_pkg::PAGE_W-1:0]      r_head;
    logic [fla_pkg::COUNT_W-1:0]     r_count;
    logic [fla_pkg::GROW_IDX_W-1:0]  r_grow_idx;
    logic [fla_pkg::PAGE_W-1:0]      r_res_page;
    logic [1:0]                      r_res_status;

    logic [fla_pkg::COUNT_W:0]       grow_end;
    logic                            grow_last;
    logic [fla_pkg::PAGE_W-1:0]      grow_addr;
    logic [fla_pkg::PAGE_W-1:0]      grow_data;
    logic                            ram_we;
    logic [fla_pkg::PAGE_W-1:0]      ram_waddr;
    logic [fla_pkg::PAGE_W-1:0]      ram_wdata;
    logic [fla_pkg::PAGE_W-1:0]      ram_rdata;

    // Checks on the captured request and the list state.
    assign grow_end  = {1'b0, r_count} + (fla_pkg::COUNT_W+1)'(fla_pkg::GROWTH_STEP);
    assign grow_last = (r_grow_idx == fla_pkg::GROW_IDX_W'(fla_pkg::GROWTH_STEP - 1));

    assign o_dp_status.cmd          = r_cmd;
    assign o_dp_status.head_zero    = (r_head == '0);
    assign o_dp_status.growth_full  = (grow_end > (fla_pkg::COUNT_W+1)'(fla_pkg::MAX_PAGES));
    assign o_dp_status.free_invalid = (r_page == '0) ||
                                      ({1'b0, r_page} >= r_count);
    assign o_dp_status.grow_last    = grow_last;

    // Address and link of the fresh page written in this growth step.
    assign grow_addr = r_count[fla_pkg::PAGE_W-1:0] + fla_pkg::PAGE_W'(r_grow_idx);
    assign grow_data = grow_last ? '0 : grow_addr + fla_pkg::PAGE_W'(1);

    // The link store is written by growth or by a free.
    always_comb begin
        ram_we    = i_dp_cmd.grow_write || i_dp_cmd.push;
        ram_waddr = i_dp_cmd.push ? r_page : grow_addr;
        ram_wdata = i_dp_cmd.push ? r_head : grow_data;
    end

    fla_ram #(
        .WIDTH (fla_pkg::PAGE_W),
        .DEPTH (fla_pkg::RAM_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Head and page count of the free list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= fla_pkg::COUNT_W'(1);
        end else if (i_dp_cmd.grow_finish) begin
            r_head  <= r_count[fla_pkg::PAGE_W-1:0];
            r_count <= grow_end[fla_pkg::COUNT_W-1:0];
        end else if (i_dp_cmd.pop) begin
            r_head  <= ram_rdata;
        end else if (i_dp_cmd.push) begin
            r_head  <= r_page;
        end
    end

    // Request capture, growth index and result registers.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) begin
            r_cmd  <= i_cmd;
            r_page <= i_page_number;
        end
        if (i_dp_cmd.accept || i_dp_cmd.grow_finish) begin
            r_grow_idx <= '0;
        end else if (i_dp_cmd.grow_write) begin
            r_grow_idx <= r_grow_idx + fla_pkg::GROW_IDX_W'(1);
        end
        if (i_dp_cmd.load_result) begin
            r_res_page   <= i_dp_cmd.result_page ? r_head : '0;
            r_res_status <= i_dp_cmd.result_status;
        end
    end

    assign o_allocated_page = r_res_page;
    assign o_status         = r_res_status;

endmodule

`default_nettype wire

### rtl/fla_ctrl.sv
`default_nettype none

module fla_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire fla_pkg::t_dp_status  i_dp_status,
    output      fla_pkg::t_dp_cmd     o_dp_cmd,
    output      logic                 o_busy,
    output      logic                 o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GROW,
        S_POP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        o_dp_cmd = '0;
        o_dp_cmd.result_status = fla_pkg::STATUS_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.accept = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_dp_status.cmd == fla_pkg::CMD_FREE) begin
                    o_dp_cmd.load_result = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (i_dp_status.free_invalid) begin
                        o_dp_cmd.result_status = fla_pkg::STATUS_INVALID;
                    end else begin
                        o_dp_cmd.push = 1'b1;
                    end
                end else if (!i_dp_status.head_zero) begin
                    // The link of the head is read in this cycle.
                    n_state = S_POP;
                end else if (i_dp_status.growth_full) begin
                    o_dp_cmd.load_result   = 1'b1;
                    o_dp_cmd.result_status = fla_pkg::STATUS_FULL;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                o_dp_cmd.grow_write = 1'b1;
                if (i_dp_status.grow_last) begin
                    o_dp_cmd.grow_finish = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_POP: begin
                o_dp_cmd.pop         = 1'b1;
                o_dp_cmd.load_result = 1'b1;
                o_dp_cmd.result_page = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

### rtl/free_list_page_allocator.sv
// Channel  Ports                               Beat taken when
// -------  ----------------------------------  ------------------------------
// request  start, busy, i_cmd, i_page_number   start high and busy low
// result   o_done, o_allocated_page, o_status  o_done high (one cycle only)
//
// The result beat of a free, or of a store-full reply, is loaded in the execute state,
// that of an allocate from a non-empty list in the pop state after it: the head link
// is read through the registered read port of the link RAM. An allocate from an empty
// list first runs the grow state, one link write per fresh page, then returns to
// execute. Reset zeroes the list head and sets the page count to one; the link RAM
// needs no clearing. The beat is held for one cycle; the receiver cannot stall.
`default_nettype none

module free_list_page_allocator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic                         i_cmd,
    input  wire logic [fla_pkg::PAGE_W-1:0]   i_page_number,
    output      logic                         busy,
    output      logic                         o_done,
    output      logic [fla_pkg::PAGE_W-1:0]   o_allocated_page,
    output      logic [1:0]                   o_status
);

    fla_pkg::t_dp_cmd    dp_cmd;
    fla_pkg::t_dp_status dp_status;

    fla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd),
        .o_busy      (busy),
        .o_done      (o_done)
    );

    fla_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_cmd            (i_cmd),
        .i_page_number    (i_page_number),
        .o_dp_status      (dp_status),
        .o_allocated_page (o_allocated_page),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire

### dv/tb_free_list_page_allocator.sv
`timescale 1ns / 100ps

module tb_free_list_page_allocator;

    // A growth walks GROWTH_STEP links, so no quiet stretch should come near this.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * fla_pkg::GROWTH_STEP + 16;

    typedef struct packed {
        logic [fla_pkg::PAGE_W-1:0] page;
        logic [1:0]                 status;
    } t_alloc_result;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       start         = 1'b0;
    logic                       i_cmd         = fla_pkg::CMD_ALLOC;
    logic [fla_pkg::PAGE_W-1:0] i_page_number = '0;
    logic                       busy;
    logic                       o_done;
    logic [fla_pkg::PAGE_W-1:0] o_allocated_page;
    logic [1:0]                 o_status;

    // Our own view of the free list.
    logic [fla_pkg::PAGE_W-1:0]  list_link [fla_pkg::RAM_DEPTH];
    logic [fla_pkg::PAGE_W-1:0]  list_head;
    logic [fla_pkg::COUNT_W-1:0] page_total;

    t_alloc_result expected_results [$];
    t_alloc_result oldest_expected;
    int            pages_in_use [$];

    bit idle_enable = 1'b1;
    int error_count = 0;
    int stall_cycles = 0;
    int requests_sent = 0;
    int pages_granted = 0;
    int pages_returned = 0;
    int frees_rejected = 0;
    int store_full_replies = 0;
    int list_growths = 0;

    free_list_page_allocator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_cmd            (i_cmd),
        .i_page_number    (i_page_number),
        .busy             (busy),
        .o_done           (o_done),
        .o_allocated_page (o_allocated_page),
        .o_status         (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out the reply to one request and updates the list as the block should.
    function automatic t_alloc_result predict_page_op(
        input logic                       cmd,
        input logic [fla_pkg::PAGE_W-1:0] page
    );
        t_alloc_result res;
        int            base;
        int            step;
        res.page   = '0;
        res.status = fla_pkg::STATUS_OK;
        if (cmd == fla_pkg::CMD_ALLOC) begin
            if (list_head == '0) begin
                base = int'(page_total);
                if (base + fla_pkg::GROWTH_STEP > fla_pkg::MAX_PAGES) begin
                    res.status = fla_pkg::STATUS_FULL;
                end else begin
                    // Chain a fresh run of pages, the last one ending the list.
                    for (step = 0; step < fla_pkg::GROWTH_STEP; step++) begin
                        list_link[base + step] = (step + 1 < fla_pkg::GROWTH_STEP) ?
                                                 fla_pkg::PAGE_W'(base + step + 1) : '0;
                    end
                    list_head  = fla_pkg::PAGE_W'(base);
                    page_total = page_total + fla_pkg::COUNT_W'(fla_pkg::GROWTH_STEP);
                    list_growths++;
                end
            end
            if (res.status == fla_pkg::STATUS_OK) begin
                res.page  = list_head;
                list_head = list_link[res.page];
                pages_in_use.push_back(int'(res.page));
                pages_granted++;
            end else begin
                store_full_replies++;
            end
        end else begin
            if (page == '0 || {1'b0, page} >= page_total) begin
                res.status = fla_pkg::STATUS_INVALID;
                frees_rejected++;
            end else begin
                list_link[page] = list_head;
                list_head       = page;
                pages_returned++;
            end
        end
        return res;
    endfunction

    // Takes a random page that we were handed and have not yet given back.
    function automatic logic [fla_pkg::PAGE_W-1:0] take_page_in_use();
        int idx;
        int page;
        idx  = $urandom_range(0, pages_in_use.size() - 1);
        page = pages_in_use[idx];
        pages_in_use.delete(idx);
        return fla_pkg::PAGE_W'(page);
    endfunction

    // A page number that must be refused: the header page or one not yet grown.
    function automatic logic [fla_pkg::PAGE_W-1:0] pick_bad_page();
        if ($urandom_range(0, 2) == 0 || int'(page_total) > fla_pkg::RAM_DEPTH - 1) begin
            return '0;
        end
        return fla_pkg::PAGE_W'($urandom_range(int'(page_total), fla_pkg::RAM_DEPTH - 1));
    endfunction

    // Offers one request beat, optionally after an idle burst, and waits for it to be taken.
    task automatic send_request(input logic cmd, input logic [fla_pkg::PAGE_W-1:0] page);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_page_number <= page;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(predict_page_op(cmd, page));
        requests_sent++;
    endtask

    task automatic send_alloc();
        send_request(fla_pkg::CMD_ALLOC, fla_pkg::PAGE_W'($urandom));
    endtask

    // First growth, LIFO reuse, and the three ways a free is refused.
    task automatic test_directed_basics();
        send_request(fla_pkg::CMD_ALLOC, '1);
        send_request(fla_pkg::CMD_ALLOC, '0);
        send_alloc();
        send_request(fla_pkg::CMD_FREE, '0);
        send_request(fla_pkg::CMD_FREE, '1);
        send_request(fla_pkg::CMD_FREE, fla_pkg::PAGE_W'(page_total));
        send_request(fla_pkg::CMD_FREE, fla_pkg::PAGE_W'(2));
        send_request(fla_pkg::CMD_FREE, fla_pkg::PAGE_W'(1));
        send_alloc();
        send_alloc();
        send_request(fla_pkg::CMD_FREE, fla_pkg::PAGE_W'(3));
        send_alloc();
        // Pages 1 to 3 are each held once again; track each of them once.
        pages_in_use.delete();
        pages_in_use.push_back(1);
        pages_in_use.push_back(2);
        pages_in_use.push_back(3);
    endtask

    // Mostly allocates, so the store grows run by run until it reports full.
    task automatic test_fill_to_full();
        while (store_full_replies < 4) begin
            if (pages_in_use.size() != 0 && $urandom_range(0, 19) == 0) begin
                send_request(fla_pkg::CMD_FREE, take_page_in_use());
            end else begin
                send_alloc();
            end
        end
    endtask

    // Well-formed frees and allocates, with refused frees mixed in as noise.
    task automatic test_mixed_traffic(input int count);
        int n;
        int pick;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 && pages_in_use.size() != 0) begin
                send_request(fla_pkg::CMD_FREE, take_page_in_use());
            end else if (pick < 80) begin
                send_alloc();
            end else begin
                send_request(fla_pkg::CMD_FREE, pick_bad_page());
            end
        end
    endtask

    // Freeing a page twice makes the list loop on itself; this stays at the end.
    task automatic test_double_free();
        logic [fla_pkg::PAGE_W-1:0] victim;
        idle_enable = 1'b0;
        send_alloc();
        victim = take_page_in_use();
        send_request(fla_pkg::CMD_FREE, victim);
        send_request(fla_pkg::CMD_FREE, victim);
        send_alloc();
        send_alloc();
        test_mixed_traffic(20);
    endtask

    // Each result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, page %0d status %0d",
                         $time, o_allocated_page, o_status);
                error_count++;
            end else begin
                oldest_expected = expected_results.pop_front();
                if (o_allocated_page !== oldest_expected.page) begin
                    $display("%0t: allocated_page expected %0d actual %0d",
                             $time, oldest_expected.page, o_allocated_page);
                    error_count++;
                end
                if (o_status !== oldest_expected.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_expected.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_results.size());
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        list_head  = '0;
        page_total = fla_pkg::COUNT_W'(1);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_fill_to_full();
        test_mixed_traffic(60);
        test_double_free();

        // Let the last results come back, then watch a while for any stray beat.
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d pages granted, %0d returned, %0d frees refused.",
                 requests_sent, pages_granted, pages_returned, frees_rejected);
        $display("The list grew %0d times and the store reported full %0d times.",
                 list_growths, store_full_replies);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
